// File: rtl/core/wfr_pkg.sv
`default_nettype none
package wfr_pkg;

  localparam int PIXEL_COUNT   = 512;
  localparam int DISPLAY_COUNT = 256;
  localparam int LINE_LIMIT    = 256;

  // pixel memory address and fill count widths
  localparam int PIX_AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int PCW    = $clog2(PIXEL_COUNT + 1);

  // divider sizing: column bounds (idx * PIXEL_COUNT) and pixel sums
  localparam int PROD_W = $clog2(DISPLAY_COUNT * PIXEL_COUNT + 1);
  localparam int SUMW   = $clog2(PIXEL_COUNT * 255 + 1);
  localparam int DIVW   = (PROD_W > SUMW) ? PROD_W : SUMW;
  localparam int DCW    = $clog2(DISPLAY_COUNT + 1);
  localparam int DVSW   = (DCW > PCW) ? DCW : PCW;
  localparam int DCNTW  = $clog2(DIVW + 1);

  localparam logic [7:0] SYNC_A  = 8'hAA;
  localparam logic [7:0] SYNC_B  = 8'h55;
  localparam logic [7:0] TRAILER = 8'hFF;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] KIND_TEXT  = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_FRAME = 3'd2;
  localparam logic [2:0] KIND_DROP  = 3'd3;
  localparam logic [2:0] KIND_PIXEL = 3'd4;

  typedef struct packed {
    logic              start;
    logic [DIVW-1:0]   dividend;
    logic [DVSW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVW-1:0]   quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        go;
    logic        ack;
    logic [11:0] idx;
  } col_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } col_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/waveform_frame_receiver_unit.sv
`default_nettype none
// Byte, clear and unused-mode items pass through accept and execute; execute waits for a
// free output slot and registers the result, and a false header gives its second result
// from T_EMIT2, which also waits for a free slot. Column read: execute starts wfr_col,
// which runs the per-pixel read loop, then the bit-serial divider; out of range: C_DONE.
// One item at a time; the next is taken the cycle its result appears.
// Sync active-low reset clears control state; pixel memory uses a fill mark, not a sweep.
module waveform_frame_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [11:0] in_display_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_value,
  output logic [7:0]       out_line_length,
  output logic [7:0]       out_frame_tag,
  output logic             out_frame_ready,
  output logic             out_last
);
  import wfr_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_EXEC  = 4'b0010,
    T_EMIT2 = 4'b0100,
    T_READ  = 4'b1000
  } top_state_t;

  typedef enum logic [3:0] {
    RS_TEXT = 4'b0001,
    RS_HDR1 = 4'b0010,
    RS_HDR2 = 4'b0100,
    RS_DATA = 4'b1000
  } rx_state_t;

  top_state_t     st_r, st_nxt;
  rx_state_t      rs_r, rs_nxt;
  logic [7:0]     text_len_r, text_len_nxt;
  logic [PCW-1:0] pix_cnt_r, pix_cnt_nxt;
  logic [PCW-1:0] fill_r, fill_nxt;
  logic [7:0]     pend_id_r, pend_id_nxt;
  logic [7:0]     acc_id_r, acc_id_nxt;
  logic           rdy_r, rdy_nxt;

  logic [1:0]     mode_r;
  logic [7:0]     byte_r;
  logic [11:0]    idx_r;

  logic           out_valid_r;
  logic [2:0]     kind_r;
  logic [7:0]     data_r;
  logic [7:0]     len_r;
  logic [7:0]     id_r;
  logic           frdy_r;
  logic           last_r;

  logic           slot_free;
  logic           emit;
  logic [2:0]     e_kind;
  logic [7:0]     e_data;
  logic [7:0]     e_len;
  logic           e_last;
  logic           ram_we;
  logic [7:0]     ram_rdata;
  logic [PIX_AW-1:0] ram_raddr;

  col_req_t       col_req;
  col_rsp_t       col_rsp;

  wfr_ram #(
    .WIDTH (8),
    .DEPTH (PIXEL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pix_cnt_r[PIX_AW-1:0]),
    .wdata (byte_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wfr_col u_col (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (col_req),
    .rsp   (col_rsp),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .fill  (fill_r)
  );

  assign in_ready  = (st_r == T_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    st_nxt       = st_r;
    rs_nxt       = rs_r;
    text_len_nxt = text_len_r;
    pix_cnt_nxt  = pix_cnt_r;
    fill_nxt     = fill_r;
    pend_id_nxt  = pend_id_r;
    acc_id_nxt   = acc_id_r;
    rdy_nxt      = rdy_r;
    emit         = 1'b0;
    e_kind       = KIND_TEXT;
    e_data       = 8'd0;
    e_len        = text_len_r;
    e_last       = 1'b1;
    ram_we       = 1'b0;
    col_req.go   = 1'b0;
    col_req.ack  = 1'b0;
    col_req.idx  = idx_r;
    case (st_r)
      T_IDLE: begin
        if (in_valid) begin
          st_nxt = T_EXEC;
        end
      end
      T_EXEC: begin
        // wait for a free output slot so any result can land at once
        if (slot_free) begin
          st_nxt = T_IDLE;
          case (mode_r)
            MODE_BYTE: begin
              case (rs_r)
                RS_TEXT: begin
                  if (byte_r == SYNC_A) begin
                    rs_nxt = RS_HDR1;
                  end else if (byte_r == CH_LF) begin
                    emit         = 1'b1;
                    e_kind       = KIND_LINE;
                    text_len_nxt = 8'd0;
                  end else if (byte_r != CH_CR &&
                               text_len_r < 8'(LINE_LIMIT - 1)) begin
                    emit         = 1'b1;
                    e_data       = byte_r;
                    text_len_nxt = text_len_r + 8'd1;
                    e_len        = text_len_nxt;
                  end
                end
                RS_HDR1: begin
                  if (byte_r == SYNC_B) begin
                    rs_nxt = RS_HDR2;
                  end else begin
                    rs_nxt = RS_TEXT;
                    // false header: push 0xAA and this byte back as text
                    if ({2'b00, text_len_r} + 10'd2 < 10'(LINE_LIMIT)) begin
                      emit         = 1'b1;
                      e_data       = SYNC_A;
                      e_len        = text_len_r + 8'd1;
                      e_last       = 1'b0;
                      text_len_nxt = text_len_r + 8'd2;
                      st_nxt       = T_EMIT2;
                    end
                  end
                end
                RS_HDR2: begin
                  pend_id_nxt = byte_r;
                  pix_cnt_nxt = '0;
                  rs_nxt      = RS_DATA;
                end
                RS_DATA: begin
                  if (pix_cnt_r < PCW'(PIXEL_COUNT)) begin
                    ram_we      = 1'b1;
                    pix_cnt_nxt = pix_cnt_r + 1'b1;
                    if (pix_cnt_r >= fill_r) begin
                      fill_nxt = pix_cnt_r + 1'b1;
                    end
                  end else begin
                    emit   = 1'b1;
                    rs_nxt = RS_TEXT;
                    if (byte_r == TRAILER) begin
                      acc_id_nxt = pend_id_r;
                      rdy_nxt    = 1'b1;
                      e_kind     = KIND_FRAME;
                    end else begin
                      e_kind = KIND_DROP;
                    end
                  end
                end
                default: begin
                  rs_nxt = RS_TEXT;
                end
              endcase
            end
            MODE_READ: begin
              col_req.go = 1'b1;
              st_nxt     = T_READ;
            end
            MODE_CLEAR: begin
              rdy_nxt = 1'b0;
            end
            default: begin
              st_nxt = T_IDLE;
            end
          endcase
        end
      end
      T_EMIT2: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_data = byte_r;
          st_nxt = T_IDLE;
        end
      end
      T_READ: begin
        if (col_rsp.done && slot_free) begin
          emit        = 1'b1;
          e_kind      = KIND_PIXEL;
          e_data      = col_rsp.value;
          col_req.ack = 1'b1;
          st_nxt      = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      rs_r        <= RS_TEXT;
      text_len_r  <= '0;
      pix_cnt_r   <= '0;
      fill_r      <= '0;
      pend_id_r   <= '0;
      acc_id_r    <= '0;
      rdy_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      rs_r       <= rs_nxt;
      text_len_r <= text_len_nxt;
      pix_cnt_r  <= pix_cnt_nxt;
      fill_r     <= fill_nxt;
      pend_id_r  <= pend_id_nxt;
      acc_id_r   <= acc_id_nxt;
      rdy_r      <= rdy_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      byte_r <= in_rx_byte;
      idx_r  <= in_display_index;
    end
    if (emit) begin
      kind_r <= e_kind;
      data_r <= e_data;
      len_r  <= e_len;
      id_r   <= acc_id_nxt;
      frdy_r <= rdy_nxt;
      last_r <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_data_value  = data_r;
  assign out_line_length = len_r;
  assign out_frame_tag   = id_r;
  assign out_frame_ready = frdy_r;
  assign out_last        = last_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> st_r == T_EXEC)
    else $error("accepted item not taken into execution");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PCW'(PIXEL_COUNT) && pix_cnt_r <= PCW'(PIXEL_COUNT))
    else $error("pixel fill mark or counter past memory depth");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    9'(text_len_r) < 9'(LINE_LIMIT))
    else $error("text line length reached the line limit");

endmodule
`default_nettype wire

// File: rtl/core/wfr_ram.sv
`default_nettype none
module wfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/wfr_div.sv
`default_nettype none
module wfr_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wfr_pkg::div_req_t req,
  output wfr_pkg::div_rsp_t      rsp
);
  import wfr_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [DCNTW-1:0] cnt_r;
  logic [DVSW-1:0]  rem_r;
  logic [DIVW-1:0]  quo_r;
  logic [DVSW-1:0]  dvs_r;

  logic [DVSW:0]    rem_sh;
  logic             ge;
  logic [DVSW:0]    rem_sub;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVW-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNTW'(DIVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVW-2:0], ge};
      rem_r <= ge ? rem_sub[DVSW-1:0] : rem_sh[DVSW-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a preceding busy cycle");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with exhausted bit count");

endmodule
`default_nettype wire

// File: rtl/core/wfr_col.sv
`default_nettype none
module wfr_col (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire wfr_pkg::col_req_t          req,
  output wfr_pkg::col_rsp_t               rsp,
  output logic [wfr_pkg::PIX_AW-1:0]      raddr,
  input  wire logic [7:0]                 rdata,
  input  wire logic [wfr_pkg::PCW-1:0]    fill
);
  import wfr_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_ADDR = 5'b00010,
    C_ACC  = 5'b00100,
    C_AVG  = 5'b01000,
    C_DONE = 5'b10000
  } col_state_t;

  col_state_t        st_r, st_nxt;
  logic [PIX_AW-1:0] addr_r, addr_nxt;
  logic [PCW-1:0]    cnt_r, cnt_nxt;
  logic [PCW-1:0]    left_r, left_nxt;
  logic [SUMW-1:0]   sum_r, sum_nxt;
  logic [7:0]        val_r, val_nxt;

  div_req_t          dreq;
  div_rsp_t          drsp;

  logic [DIVW-1:0]   q;
  logic [DIVW-1:0]   lo_q;
  logic [DIVW-1:0]   hi_q;
  logic [PIX_AW-1:0] q_start;
  logic [PCW-1:0]    q_end;
  logic [PCW-1:0]    span;
  logic [7:0]        pix;
  logic [SUMW-1:0]   sum_add;

  wfr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign raddr = addr_r;

  always_comb begin
    q       = drsp.quotient;
    // column window bounds; DISPLAY_COUNT is a power of two, so the divide is a shift
    lo_q    = (DIVW'(req.idx) * DIVW'(PIXEL_COUNT)) / DIVW'(DISPLAY_COUNT);
    hi_q    = ((DIVW'(req.idx) + DIVW'(1)) * DIVW'(PIXEL_COUNT)) / DIVW'(DISPLAY_COUNT);
    q_start = (lo_q >= DIVW'(PIXEL_COUNT)) ? PIX_AW'(PIXEL_COUNT - 1) : lo_q[PIX_AW-1:0];
    q_end   = (hi_q > DIVW'(PIXEL_COUNT)) ? PCW'(PIXEL_COUNT) : hi_q[PCW-1:0];
    // empty window reads one pixel at the window start
    span    = (q_end > PCW'(q_start)) ? (q_end - PCW'(q_start)) : PCW'(1);
    // entries past the fill mark were never written and read as zero
    pix     = (PCW'(addr_r) < fill) ? rdata : 8'd0;
    sum_add = sum_r + SUMW'(pix);
  end

  always_comb begin
    st_nxt    = st_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    val_nxt   = val_r;
    dreq      = '0;
    case (st_r)
      C_IDLE: begin
        if (req.go) begin
          if (req.idx >= 12'(DISPLAY_COUNT)) begin
            val_nxt = 8'd0;
            st_nxt  = C_DONE;
          end else begin
            cnt_nxt  = span;
            left_nxt = span;
            addr_nxt = q_start;
            sum_nxt  = '0;
            st_nxt   = C_ADDR;
          end
        end
      end
      C_ADDR: begin
        st_nxt = C_ACC;
      end
      C_ACC: begin
        sum_nxt  = sum_add;
        addr_nxt = addr_r + 1'b1;
        left_nxt = left_r - 1'b1;
        if (left_r == PCW'(1)) begin
          dreq.start    = 1'b1;
          dreq.dividend = DIVW'(sum_add);
          dreq.divisor  = DVSW'(cnt_r);
          st_nxt        = C_AVG;
        end else begin
          st_nxt = C_ADDR;
        end
      end
      C_AVG: begin
        if (drsp.done) begin
          val_nxt = q[7:0];
          st_nxt  = C_DONE;
        end
      end
      C_DONE: begin
        if (req.ack) begin
          st_nxt = C_IDLE;
        end
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    cnt_r   <= cnt_nxt;
    left_r  <= left_nxt;
    sum_r   <= sum_nxt;
    val_r   <= val_nxt;
  end

  assign rsp.done  = (st_r == C_DONE);
  assign rsp.value = val_r;

endmodule
`default_nettype wire
